// ===== src/tmq_pkg.sv =====
`default_nettype none
package tmq_pkg;

   // table geometry
   localparam int DEPTH  = 32;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // field widths
   localparam int TIME_W = 32;
   localparam int TALK_W = 4;
   localparam int FRAG_W = 12;
   localparam int CLS_W  = 3;
   localparam int FLAG_W = 7;
   localparam int MSG_W  = 6;

   // register defaults and limits
   localparam logic [TIME_W-1:0] TTL_DEFAULT = 32'd8000;
   localparam logic [MSG_W-1:0]  MSG_DEFAULT = 6'd20;
   localparam logic [MSG_W-1:0]  MSG_CAP     = 6'd32;

   // register indexes
   localparam logic [1:0] CSR_TTL = 2'd0;
   localparam logic [1:0] CSR_MAX = 2'd1;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_ACK   = 2'd0,
      KIND_ENTRY = 2'd1,
      KIND_EMPTY = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_QUERY
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] start;
      logic [TALK_W-1:0] talker;
      logic [FRAG_W-1:0] fragment;
      logic [CLS_W-1:0]  cls;
   } entry_type;

   // results of the shared time compare unit
   typedef struct packed {
      logic expired;
      logic live;
      logic later;
      logic not_earlier;
   } cmp_type;

   // lowest set flag, or seven when none is set
   function automatic logic [CLS_W-1:0] class_of(input logic [FLAG_W-1:0] flags);
      logic [CLS_W-1:0] cls;
      cls = CLS_W'(FLAG_W);
      for (int b = FLAG_W - 1; b >= 0; b--) begin
         if (flags[b]) begin
            cls = CLS_W'(b);
         end
      end
      return cls;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(DEPTH - 1) : PTR_W'(p - 1'b1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
      logic [PTR_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (PTR_W + 1)'(DEPTH)) begin
         sum = sum - (PTR_W + 1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== src/tmq_ram.sv =====
`default_nettype none
module tmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/tmq_cmp.sv =====
`default_nettype none
module tmq_cmp (
   input  wire logic [tmq_pkg::TIME_W-1:0] entry_start,
   input  wire logic [tmq_pkg::TIME_W-1:0] cur_time,
   input  wire logic [tmq_pkg::TIME_W-1:0] ttl,
   output tmq_pkg::cmp_type                res
);

   logic [tmq_pkg::TIME_W:0] end_time;
   logic [tmq_pkg::TIME_W:0] now_ext;

   // end of display window, kept one bit wider so it cannot wrap
   assign end_time = {1'b0, entry_start} + {1'b0, ttl};
   assign now_ext  = {1'b0, cur_time};

   always_comb begin
      res.expired     = end_time < now_ext;
      res.live        = (entry_start < cur_time) && (now_ext < end_time);
      res.later       = entry_start > cur_time;
      res.not_earlier = entry_start >= cur_time;
   end

endmodule
`default_nettype wire

// ===== src/timed_message_queue.sv =====
// insert: busy while stored entries that start no earlier than the new one move one slot
//   toward the tail; the acknowledge strobes in the first cycle after busy falls
// query: the scan reads one entry a cycle through the single table read port; entries
//   stream out, the last one after busy falls
// clear, no-op and an insert into a full table: acknowledge next cycle, never busy
// results cannot be stalled; synchronous reset empties the table, ttl 8000, max 20
`default_nettype none
module timed_message_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_time_stamp,
   input  wire logic [3:0]  req_talker,
   input  wire logic [11:0] req_fragment,
   input  wire logic [6:0]  req_channel_flags,
   output logic             rsp_valid,
   output logic [1:0]       rsp_kind,
   output logic [3:0]       rsp_out_talker,
   output logic [11:0]      rsp_out_fragment,
   output logic [2:0]       rsp_channel_class,
   output logic [31:0]      rsp_entry_start,
   output logic             rsp_overflow,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int PTR_W = tmq_pkg::PTR_W;
   localparam int CNT_W = tmq_pkg::CNT_W;
   localparam int MSG_W = tmq_pkg::MSG_W;
   localparam int ENT_W = $bits(tmq_pkg::entry_type);

   tmq_pkg::state_type state_ff, state_in;
   tmq_pkg::op_type    req_op;
   logic               accept;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] hole_ff, hole_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic             vld_ff, vld_in;
   logic             expire_ff, expire_in;
   logic [MSG_W-1:0] n_ff, n_in;
   logic [31:0]      t_ff, t_in;
   tmq_pkg::entry_type new_ff, new_in;
   logic               pend_vld_ff, pend_vld_in;
   tmq_pkg::entry_type pend_ff, pend_in;

   logic [31:0]      ttl_ff, ttl_in;
   logic [MSG_W-1:0] max_ff, max_in;
   logic [MSG_W-1:0] max_wr;

   logic               rsp_valid_ff, rsp_valid_in;
   tmq_pkg::kind_type  rsp_kind_ff, rsp_kind_in;
   tmq_pkg::entry_type rsp_entry_ff, rsp_entry_in;
   logic               rsp_ovf_ff, rsp_ovf_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               ram_wr_en;
   logic [PTR_W-1:0]   ram_wr_addr;
   tmq_pkg::entry_type ram_wr_data;
   logic               ram_rd_en;
   tmq_pkg::entry_type ram_rd_data;
   logic [ENT_W-1:0]   ram_rd_bits;

   tmq_pkg::cmp_type   cmp_res;
   logic               ins_done;
   logic               qry_done;
   logic               walk;
   logic               emit;
   logic [PTR_W-1:0]   tail;

   assign req_op    = tmq_pkg::op_type'(req_operation);
   assign busy      = (state_ff != tmq_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign tail      = tmq_pkg::ptr_add(head_ff, count_ff[PTR_W-1:0]);
   assign max_wr    = csr_wdata[MSG_W-1:0];
   assign ram_rd_data = tmq_pkg::entry_type'(ram_rd_bits);

   // entry table
   tmq_ram #(
      .WIDTH(ENT_W),
      .DEPTH(tmq_pkg::DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(rd_ptr_ff),
      .rd_data(ram_rd_bits)
   );

   // shared time compare on the entry just read
   tmq_cmp u_cmp (
      .entry_start(ram_rd_data.start),
      .cur_time   (t_ff),
      .ttl        (ttl_ff),
      .res        (cmp_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tmq_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_op == tmq_pkg::OP_INSERT &&
                   count_ff < CNT_W'(tmq_pkg::DEPTH)) begin
                  state_in = tmq_pkg::ST_INSERT;
               end else if (req_op == tmq_pkg::OP_QUERY) begin
                  state_in = tmq_pkg::ST_QUERY;
               end
            end
         end
         tmq_pkg::ST_INSERT: begin
            if (ins_done) begin
               state_in = tmq_pkg::ST_IDLE;
            end
         end
         tmq_pkg::ST_QUERY: begin
            if (qry_done) begin
               state_in = tmq_pkg::ST_IDLE;
            end
         end
         default: state_in = tmq_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      hole_in      = hole_ff;
      rem_in       = rem_ff;
      vld_in       = 1'b0;
      expire_in    = expire_ff;
      n_in         = n_ff;
      t_in         = t_ff;
      new_in       = new_ff;
      pend_vld_in  = pend_vld_ff;
      pend_in      = pend_ff;
      ttl_in       = ttl_ff;
      max_in       = max_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = hole_ff;
      ram_wr_data  = new_ff;
      ram_rd_en    = 1'b0;
      ins_done     = 1'b0;
      qry_done     = 1'b0;
      walk         = 1'b0;
      emit         = 1'b0;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            tmq_pkg::CSR_TTL: begin
               ttl_in = (csr_wdata == '0) ? tmq_pkg::TTL_DEFAULT : csr_wdata;
            end
            tmq_pkg::CSR_MAX: begin
               if (max_wr == '0) begin
                  max_in = tmq_pkg::MSG_DEFAULT;
               end else if (max_wr > tmq_pkg::MSG_CAP) begin
                  max_in = tmq_pkg::MSG_CAP;
               end else begin
                  max_in = max_wr;
               end
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         tmq_pkg::ST_IDLE: begin
            if (accept) begin
               t_in        = req_time_stamp;
               new_in      = '{start:    req_time_stamp,
                               talker:   req_talker,
                               fragment: req_fragment,
                               cls:      tmq_pkg::class_of(req_channel_flags)};
               n_in        = '0;
               pend_vld_in = 1'b0;
               expire_in   = 1'b1;
               rem_in      = count_ff;
               // acknowledge for everything but a started insert or query
               rsp_kind_in  = tmq_pkg::KIND_ACK;
               rsp_entry_in = '0;
               rsp_ovf_in   = 1'b0;
               rsp_last_in  = 1'b1;
               unique case (req_op)
                  tmq_pkg::OP_INSERT: begin
                     if (count_ff >= CNT_W'(tmq_pkg::DEPTH)) begin
                        rsp_valid_in = 1'b1;
                        rsp_ovf_in   = 1'b1;
                     end else begin
                        hole_in   = tail;
                        rd_ptr_in = tmq_pkg::ptr_dec(tail);
                     end
                  end
                  tmq_pkg::OP_QUERY: begin
                     rd_ptr_in = head_ff;
                  end
                  tmq_pkg::OP_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         tmq_pkg::ST_INSERT: begin
            // read entries from the tail down
            if (rem_ff != '0) begin
               ram_rd_en = 1'b1;
               rd_ptr_in = tmq_pkg::ptr_dec(rd_ptr_ff);
               rem_in    = rem_ff - CNT_W'(1);
               vld_in    = 1'b1;
            end
            // move a later-or-equal entry up one slot, else drop the new one in
            if (vld_ff) begin
               if (cmp_res.not_earlier) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = ram_rd_data;
                  hole_in     = tmq_pkg::ptr_dec(hole_ff);
               end else begin
                  ram_wr_en = 1'b1;
                  ins_done  = 1'b1;
               end
            end else if (rem_ff == '0) begin
               ram_wr_en = 1'b1;
               ins_done  = 1'b1;
            end
            if (ins_done) begin
               vld_in       = 1'b0;
               count_in     = count_ff + CNT_W'(1);
               rsp_valid_in = 1'b1;
               rsp_kind_in  = tmq_pkg::KIND_ACK;
               rsp_entry_in = '0;
               rsp_ovf_in   = 1'b0;
               rsp_last_in  = 1'b1;
            end
         end

         tmq_pkg::ST_QUERY: begin
            // read entries from the head up
            if (rem_ff != '0) begin
               ram_rd_en = 1'b1;
               rd_ptr_in = tmq_pkg::ptr_inc(rd_ptr_ff);
               rem_in    = rem_ff - CNT_W'(1);
               vld_in    = 1'b1;
            end
            if (vld_ff) begin
               // expire head entries first, then walk
               if (expire_ff && cmp_res.expired) begin
                  head_in  = tmq_pkg::ptr_inc(head_ff);
                  count_in = count_ff - CNT_W'(1);
               end else begin
                  expire_in = 1'b0;
                  walk      = 1'b1;
               end
               if (walk) begin
                  if (n_ff == max_ff || cmp_res.later) begin
                     qry_done = 1'b1;
                  end else if (cmp_res.live) begin
                     emit = 1'b1;
                  end
               end
            end else if (rem_ff == '0) begin
               qry_done = 1'b1;
            end
            // a live entry is held in the pending register so the final one can carry last
            if (emit) begin
               if (pend_vld_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = tmq_pkg::KIND_ENTRY;
                  rsp_entry_in = pend_ff;
                  rsp_ovf_in   = 1'b0;
                  rsp_last_in  = 1'b0;
               end
               pend_in     = ram_rd_data;
               pend_vld_in = 1'b1;
               n_in        = n_ff + MSG_W'(1);
            end
            if (qry_done) begin
               vld_in       = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_ovf_in   = 1'b0;
               rsp_last_in  = 1'b1;
               if (pend_vld_ff) begin
                  rsp_kind_in  = tmq_pkg::KIND_ENTRY;
                  rsp_entry_in = pend_ff;
               end else begin
                  rsp_kind_in  = tmq_pkg::KIND_EMPTY;
                  rsp_entry_in = '0;
               end
            end
         end

         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmq_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         vld_ff       <= 1'b0;
         expire_ff    <= 1'b0;
         pend_vld_ff  <= 1'b0;
         n_ff         <= '0;
         rem_ff       <= '0;
         ttl_ff       <= tmq_pkg::TTL_DEFAULT;
         max_ff       <= tmq_pkg::MSG_DEFAULT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         vld_ff       <= vld_in;
         expire_ff    <= expire_in;
         pend_vld_ff  <= pend_vld_in;
         n_ff         <= n_in;
         rem_ff       <= rem_in;
         ttl_ff       <= ttl_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      hole_ff      <= hole_in;
      t_ff         <= t_in;
      new_ff       <= new_in;
      pend_ff      <= pend_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_out_talker    = rsp_entry_ff.talker;
   assign rsp_out_fragment  = rsp_entry_ff.fragment;
   assign rsp_channel_class = rsp_entry_ff.cls;
   assign rsp_entry_start   = rsp_entry_ff.start;
   assign rsp_overflow      = rsp_ovf_ff;
   assign rsp_last          = rsp_last_ff;

endmodule
`default_nettype wire

// ===== src/tmq_checker.sv =====
`default_nettype none
module tmq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [1:0]  req_operation,
   input wire logic        rsp_valid,
   input wire logic [1:0]  rsp_kind,
   input wire logic [3:0]  rsp_out_talker,
   input wire logic [11:0] rsp_out_fragment,
   input wire logic [2:0]  rsp_channel_class,
   input wire logic [31:0] rsp_entry_start,
   input wire logic        rsp_overflow,
   input wire logic        rsp_last
);

   // anything but a live entry is a single, final result
   a_single_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != tmq_pkg::KIND_ENTRY |-> rsp_last)
      else $error("non-entry result without last");

   // overflow only on an acknowledge
   a_ovf_ack : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_kind == tmq_pkg::KIND_ACK)
      else $error("overflow on a non-acknowledge result");

   // entry fields are zero outside live entries
   a_zero_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != tmq_pkg::KIND_ENTRY |->
         rsp_out_talker == '0 && rsp_out_fragment == '0 &&
         rsp_channel_class == '0 && rsp_entry_start == '0)
      else $error("entry fields set outside a live entry");

   // clear acknowledges in the next cycle
   a_clear_ack : assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_operation == tmq_pkg::OP_CLEAR |=>
         rsp_valid && rsp_last && !rsp_overflow && rsp_kind == tmq_pkg::KIND_ACK)
      else $error("clear not acknowledged");

   // a query still streaming keeps the block busy
   a_stream_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("partial query result while idle");

endmodule

bind timed_message_queue tmq_checker u_tmq_checker (.*);
`default_nettype wire

// ===== dv/timed_message_queue_test.sv =====
module timed_message_queue_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int IDLE_PERCENT = 19;

   // one result as the block should present it
   typedef struct packed {
      logic [1:0]                 kind;
      logic [tmq_pkg::TALK_W-1:0] talker;
      logic [tmq_pkg::FRAG_W-1:0] fragment;
      logic [tmq_pkg::CLS_W-1:0]  cls;
      logic [tmq_pkg::TIME_W-1:0] start;
      logic                       overflow;
      logic                       last;
   } result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_operation;
   logic [31:0]       req_time_stamp;
   logic [3:0]        req_talker;
   logic [11:0]       req_fragment;
   logic [6:0]        req_channel_flags;
   logic              rsp_valid;
   logic [1:0]        rsp_kind;
   logic [3:0]        rsp_out_talker;
   logic [11:0]       rsp_out_fragment;
   logic [2:0]        rsp_channel_class;
   logic [31:0]       rsp_entry_start;
   logic              rsp_overflow;
   logic              rsp_last;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_index;
   logic [31:0]       csr_wdata;

   // shadow of the sorted table and the active settings
   tmq_pkg::entry_type         table_model[$];
   logic [tmq_pkg::TIME_W-1:0] ttl_ticks = tmq_pkg::TTL_DEFAULT;
   int                         msg_limit = int'(tmq_pkg::MSG_DEFAULT);
   result_type                 pending_responses[$];

   int                error_count = 0;
   int                quiet_cycles = 0;
   bit                idle_enabled = 1'b1;

   timed_message_queue dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_time_stamp    (req_time_stamp),
      .req_talker        (req_talker),
      .req_fragment      (req_fragment),
      .req_channel_flags (req_channel_flags),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_out_talker    (rsp_out_talker),
      .rsp_out_fragment  (rsp_out_fragment),
      .rsp_channel_class (rsp_channel_class),
      .rsp_entry_start   (rsp_entry_start),
      .rsp_overflow      (rsp_overflow),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // lowest set flag wins, seven when no flag is set
   function automatic logic [tmq_pkg::CLS_W-1:0] lowest_flag(
         input logic [tmq_pkg::FLAG_W-1:0] flags);
      for (int b = 0; b < tmq_pkg::FLAG_W; b++) begin
         if (flags[b]) begin
            return tmq_pkg::CLS_W'(b);
         end
      end
      return 3'd7;
   endfunction

   // random flags with every class likely
   function automatic logic [tmq_pkg::FLAG_W-1:0] random_flags();
      return 7'($urandom) & (7'h7F << $urandom_range(0, 7));
   endfunction

   // update the shadow table and queue the results one request causes
   task automatic predict_response(input tmq_pkg::op_type op, input logic [31:0] stamp,
                                   input logic [3:0] talker, input logic [11:0] fragment,
                                   input logic [6:0] flags);
      result_type         r;
      tmq_pkg::entry_type e;
      int                 pos;
      int                 emitted;
      r = '0;
      r.kind = tmq_pkg::KIND_ACK;
      r.last = 1'b1;
      case (op)
         tmq_pkg::OP_INSERT: begin
            if (table_model.size() >= tmq_pkg::DEPTH) begin
               r.overflow = 1'b1;
            end else begin
               pos = 0;
               while (pos < table_model.size() && table_model[pos].start < stamp) begin
                  pos++;
               end
               e.start    = stamp;
               e.talker   = talker;
               e.fragment = fragment;
               e.cls      = lowest_flag(flags);
               table_model.insert(pos, e);
            end
            pending_responses.push_back(r);
         end
         tmq_pkg::OP_QUERY: begin
            // expire the head, sum taken at 33 bits
            while (table_model.size() > 0 &&
                   ({1'b0, table_model[0].start} + {1'b0, ttl_ticks}) < {1'b0, stamp}) begin
               void'(table_model.pop_front());
            end
            // walk until a future start or the per-query limit
            emitted = 0;
            pos = 0;
            while (pos < table_model.size() && emitted < msg_limit &&
                   table_model[pos].start <= stamp) begin
               e = table_model[pos];
               if (e.start < stamp &&
                   {1'b0, stamp} < ({1'b0, e.start} + {1'b0, ttl_ticks})) begin
                  r = '0;
                  r.kind     = tmq_pkg::KIND_ENTRY;
                  r.talker   = e.talker;
                  r.fragment = e.fragment;
                  r.cls      = e.cls;
                  r.start    = e.start;
                  pending_responses.push_back(r);
                  emitted++;
               end
               pos++;
            end
            if (emitted == 0) begin
               r = '0;
               r.kind = tmq_pkg::KIND_EMPTY;
               r.last = 1'b1;
               pending_responses.push_back(r);
            end else begin
               pending_responses[$].last = 1'b1;
            end
         end
         tmq_pkg::OP_CLEAR: begin
            table_model.delete();
            pending_responses.push_back(r);
         end
         default: begin
            pending_responses.push_back(r);
         end
      endcase
   endtask

   // present one request, hold it until accepted, then predict
   task automatic send_request(input tmq_pkg::op_type op, input logic [31:0] stamp,
                               input logic [3:0] talker, input logic [11:0] fragment,
                               input logic [6:0] flags);
      if (idle_enabled && $urandom_range(0, 99) < IDLE_PERCENT) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start             <= 1'b1;
      req_operation     <= op;
      req_time_stamp    <= stamp;
      req_talker        <= talker;
      req_fragment      <= fragment;
      req_channel_flags <= flags;
      do @(posedge clock); while (busy);
      predict_response(op, stamp, talker, fragment, flags);
   endtask

   // stop requesting and wait for every expected result
   task automatic drain_responses();
      start <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   // write both registers back to back, block must be idle
   task automatic write_settings(input logic [31:0] ttl_value, input logic [31:0] max_value);
      logic [tmq_pkg::MSG_W-1:0] m;
      csr_valid <= 1'b1;
      csr_index <= tmq_pkg::CSR_TTL;
      csr_wdata <= ttl_value;
      do @(posedge clock); while (!csr_ready);
      ttl_ticks = (ttl_value == 0) ? tmq_pkg::TTL_DEFAULT : ttl_value;
      csr_index <= tmq_pkg::CSR_MAX;
      csr_wdata <= max_value;
      do @(posedge clock); while (!csr_ready);
      m = max_value[tmq_pkg::MSG_W-1:0];
      if (m == 0) begin
         m = tmq_pkg::MSG_DEFAULT;
      end
      if (m > tmq_pkg::MSG_CAP) begin
         m = tmq_pkg::MSG_CAP;
      end
      msg_limit = int'(m);
      csr_valid <= 1'b0;
   endtask

   // expiry and live window boundaries at the reset settings
   task automatic test_expiry_edges();
      send_request(tmq_pkg::OP_QUERY, 32'd0, 4'd0, 12'd0, 7'd0);
      send_request(tmq_pkg::OP_INSERT, 32'd100, 4'd3, 12'h123, 7'h04);
      send_request(tmq_pkg::OP_QUERY, 32'd100, 4'd0, 12'd0, 7'd0);
      send_request(tmq_pkg::OP_QUERY, 32'd101, 4'd0, 12'd0, 7'd0);
      send_request(tmq_pkg::OP_QUERY, 32'd8100, 4'd0, 12'd0, 7'd0);
      send_request(tmq_pkg::OP_QUERY, 32'd8101, 4'd0, 12'd0, 7'd0);
   endtask

   // field extremes, equal starts, no-op and clear at the widest ttl
   task automatic test_field_extremes();
      drain_responses();
      write_settings(32'hFFFF_FFFF, 32'd63);
      send_request(tmq_pkg::OP_INSERT, 32'd0, 4'hF, 12'hFFF, 7'h00);
      send_request(tmq_pkg::OP_INSERT, 32'hFFFF_FFFF, 4'h0, 12'h000, 7'h40);
      send_request(tmq_pkg::OP_INSERT, 32'd50, 4'h5, 12'hA5A, 7'h7F);
      send_request(tmq_pkg::OP_INSERT, 32'd50, 4'h6, 12'h5A5, 7'h10);
      send_request(tmq_pkg::OP_QUERY, 32'hFFFF_FFFF, 4'h0, 12'h000, 7'h00);
      send_request(tmq_pkg::OP_QUERY, 32'd1, 4'hF, 12'hFFF, 7'h7F);
      send_request(tmq_pkg::OP_NOP, 32'hFFFF_FFFF, 4'hF, 12'hFFF, 7'h7F);
      send_request(tmq_pkg::OP_CLEAR, 32'hFFFF_FFFF, 4'hF, 12'hFFF, 7'h7F);
      send_request(tmq_pkg::OP_QUERY, 32'd60, 4'h0, 12'h000, 7'h00);
   endtask

   // fill the table back to back, overflow, then query at both limits
   task automatic test_fill_and_overflow();
      logic [31:0] base;
      drain_responses();
      write_settings(32'd5000, 32'd0);
      idle_enabled = 1'b0;
      base = $urandom_range(100000, 32'h8000_0000);
      send_request(tmq_pkg::OP_CLEAR, 32'd0, 4'd0, 12'd0, 7'd0);
      repeat (tmq_pkg::DEPTH) begin
         send_request(tmq_pkg::OP_INSERT, base + $urandom_range(0, 1000), 4'($urandom),
                      12'($urandom), random_flags());
      end
      send_request(tmq_pkg::OP_INSERT, base, 4'($urandom), 12'($urandom), random_flags());
      send_request(tmq_pkg::OP_QUERY, base + 1001, 4'd0, 12'd0, 7'd0);
      drain_responses();
      write_settings(32'd5000, 32'd32);
      send_request(tmq_pkg::OP_QUERY, base + 1001, 4'd0, 12'd0, 7'd0);
      send_request(tmq_pkg::OP_CLEAR, 32'd0, 4'd0, 12'd0, 7'd0);
      idle_enabled = 1'b1;
   endtask

   // mostly time-ordered traffic around a moving clock, some noise
   task automatic run_random_phase(input logic [31:0] ttl_value,
                                   input logic [31:0] max_value, input int count);
      logic [31:0] now;
      logic [31:0] last_start;
      logic [31:0] span;
      int          roll;
      drain_responses();
      write_settings(ttl_value, max_value);
      span = (ttl_ticks < 2000) ? ttl_ticks * 2 + 4 : 32'd4000;
      now = $urandom_range(0, 32'hF000_0000);
      last_start = now;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            // a few repeat the previous start to exercise ties
            if (roll < 37) begin
               last_start = now + $urandom_range(0, span);
            end
            send_request(tmq_pkg::OP_INSERT, last_start, 4'($urandom), 12'($urandom),
                         random_flags());
         end else if (roll < 80) begin
            now = now + $urandom_range(0, span);
            send_request(tmq_pkg::OP_QUERY, now, 4'($urandom), 12'($urandom),
                         random_flags());
         end else if (roll < 85) begin
            send_request(tmq_pkg::OP_CLEAR, $urandom, 4'($urandom), 12'($urandom),
                         random_flags());
         end else if (roll < 90) begin
            send_request(tmq_pkg::OP_NOP, $urandom, 4'($urandom), 12'($urandom),
                         random_flags());
         end else begin
            send_request(roll[0] ? tmq_pkg::OP_INSERT : tmq_pkg::OP_QUERY, $urandom,
                         4'($urandom), 12'($urandom), random_flags());
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(32'd300, 32'd5, 10);
      run_random_phase(32'd1, 32'd1, 10);
      run_random_phase(32'hFFFF_FFFF, 32'd40, 10);
      run_random_phase($urandom_range(1, 20000), $urandom_range(0, 63), 10);
      run_random_phase(32'd0, 32'd0, 10);
   endtask

   task automatic report_field(input string field_name, input logic [31:0] wanted,
                               input logic [31:0] seen);
      if (seen !== wanted) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field_name, wanted, seen);
         error_count++;
      end
   endtask

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      result_type wanted;
      if (!reset && rsp_valid) begin
         if (pending_responses.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind 0x%0h",
                     $time, rsp_kind);
            error_count++;
         end else begin
            wanted = pending_responses.pop_front();
            report_field("kind", 32'(wanted.kind), 32'(rsp_kind));
            report_field("talker", 32'(wanted.talker), 32'(rsp_out_talker));
            report_field("fragment", 32'(wanted.fragment), 32'(rsp_out_fragment));
            report_field("channel class", 32'(wanted.cls), 32'(rsp_channel_class));
            report_field("entry start", wanted.start, rsp_entry_start);
            report_field("overflow", 32'(wanted.overflow), 32'(rsp_overflow));
            report_field("last", 32'(wanted.last), 32'(rsp_last));
         end
      end
   end

   // watchdog on cycles with no handshake of any kind; unexpected results do not count
   always @(posedge clock) begin
      if (reset || (start && !busy) || (rsp_valid && pending_responses.size() != 0) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      start             <= 1'b0;
      req_operation     <= tmq_pkg::OP_NOP;
      req_time_stamp    <= '0;
      req_talker        <= '0;
      req_fragment      <= '0;
      req_channel_flags <= '0;
      csr_valid         <= 1'b0;
      csr_index         <= tmq_pkg::CSR_TTL;
      csr_wdata         <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_expiry_edges();
      test_field_extremes();
      test_fill_and_overflow();
      test_random_traffic();

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/tmq_pkg.sv
src/tmq_ram.sv
src/tmq_cmp.sv
src/timed_message_queue.sv
src/tmq_checker.sv
dv/timed_message_queue_test.sv
